>>> rtl/core/stis_pkg.sv
// Shared types and constants for the sorted table insert and search unit.
`default_nettype none

package stis_pkg;

  localparam int unsigned DEFAULT_CAPACITY = 16;
  localparam int unsigned VALUE_W          = 32;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_SEARCH = 2'd1;
  localparam logic [1:0] ACT_DUMP   = 2'd2;

  typedef struct packed {
    logic [1:0]                 action;
    logic signed [VALUE_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic                       found;
    logic signed [VALUE_W-1:0]  entry_value;
    logic                       entry_valid;
    logic                       last;
    logic                       dropped;
  } out_item_t;

  // Commands broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic shift_in;
    logic rotate;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/sorted_table_insert_search_unit.sv
// Top level of the sorted table: sequencer, output register and a chain of storage cells.
`default_nettype none

// The unit keeps up to CAPACITY signed 32-bit values in ascending order in a
// chain of cells, one value per cell. Items are taken one at a time: an insert
// compares all cells against the new value in parallel and shifts the ones not
// smaller than it one place to the right in a single step, a search registers
// per-cell match flags and then OR-reduces them, and a dump rotates the chain by
// one cell per cycle while the result side does not stall, so that cell zero feeds
// the result register. An empty dump gives one result with entry_valid low. An
// insert into a full table leaves the table unchanged and sets dropped. Action
// code 3 is ignored. The result register lets the next item transfer in while a
// result still waits; a stall on the result side holds the chain in place. No
// clearing pass is needed after reset: the fill count alone tells which cells
// hold values.

module sorted_table_insert_search_unit #(
  parameter int unsigned CAPACITY = stis_pkg::DEFAULT_CAPACITY
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  stis_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output stis_pkg::out_item_t out_data_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_OP   = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;
  localparam logic [1:0] S_DUMP = 2'd3;

  logic [1:0] state_q, state_d;
  logic [1:0] op_q;
  logic signed [stis_pkg::VALUE_W-1:0] key_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] dcnt_q, dcnt_d;

  stis_pkg::out_item_t out_q, out_d;
  logic                out_valid_q, out_valid_d;
  logic                out_free;
  logic                emit;

  stis_pkg::cell_ctrl_t cell_ctrl;
  logic signed [stis_pkg::VALUE_W-1:0] entry [CAPACITY];
  logic                                take  [CAPACITY];
  logic [CAPACITY-1:0]                 hit;

  logic in_xfer;
  logic full;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign full     = (count_q == CNT_W'(CAPACITY));

  // The chain of cells. Cell zero has no left neighbor; the last cell's right
  // neighbor only reaches it while it is free, because when it holds a value it is the wrap point.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                                left_take;
    logic signed [stis_pkg::VALUE_W-1:0] left_entry;
    logic signed [stis_pkg::VALUE_W-1:0] right_entry;

    if (i == 0) begin : g_first
      assign left_take  = 1'b0;
      assign left_entry = key_q;
    end else begin : g_inner
      assign left_take  = take[i-1];
      assign left_entry = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign right_entry = entry[0];
    end else begin : g_mid
      assign right_entry = entry[i+1];
    end

    stis_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (cell_ctrl),
      .key_i         (key_q),
      .occupied_i    (CNT_W'(i) < count_q),
      .tail_i        (CNT_W'(i) == count_q),
      .wrap_i        (CNT_W'(i + 1) == count_q),
      .left_take_i   (left_take),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .head_entry_i  (entry[0]),
      .take_o        (take[i]),
      .entry_o       (entry[i]),
      .hit_o         (hit[i])
    );
  end

  // Sequencer: one item at a time, each step that gives a result waits until the
  // result register can take a new result.
  always_comb begin
    state_d             = state_q;
    count_d             = count_q;
    dcnt_d              = dcnt_q;
    emit                = 1'b0;
    out_d               = '0;
    cell_ctrl.shift_in  = 1'b0;
    cell_ctrl.rotate    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_OP;
        end
      end
      S_OP: begin
        case (op_q)
          stis_pkg::ACT_INSERT: begin
            if (out_free) begin
              emit          = 1'b1;
              out_d.last    = 1'b1;
              out_d.dropped = full;
              if (!full) begin
                cell_ctrl.shift_in = 1'b1;
                count_d            = count_q + 1'b1;
              end
              state_d = S_IDLE;
            end
          end
          stis_pkg::ACT_SEARCH: begin
            // The match flags of the cells are registered at this edge.
            state_d = S_SRCH;
          end
          stis_pkg::ACT_DUMP: begin
            if (count_q == '0) begin
              if (out_free) begin
                emit       = 1'b1;
                out_d.last = 1'b1;
                state_d    = S_IDLE;
              end
            end else begin
              dcnt_d  = '0;
              state_d = S_DUMP;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_SRCH: begin
        if (out_free) begin
          emit        = 1'b1;
          out_d.found = |hit;
          out_d.last  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          emit              = 1'b1;
          out_d.entry_value = entry[0];
          out_d.entry_valid = 1'b1;
          out_d.last        = (dcnt_q + 1'b1 == count_q);
          cell_ctrl.rotate  = 1'b1;
          dcnt_d            = dcnt_q + 1'b1;
          if (dcnt_q + 1'b1 == count_q) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q  <= in_data_i.action;
      key_q <= in_data_i.value;
    end
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_xfer_starts_op : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == S_OP))
    else $error("accepted item did not start an operation");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("fill count exceeds capacity");

  a_insert_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OP && op_q == stis_pkg::ACT_INSERT && out_free && !full)
    |=> (count_q == $past(count_q) + 1'b1))
    else $error("insert into a table with room did not grow it");

  a_drop_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.dropped) |-> full)
    else $error("insert dropped while the table has room");
`endif

endmodule

`default_nettype wire

>>> rtl/core/stis_cell.sv
// One storage cell of the sorted chain: holds a value and trades it with its neighbors.
`default_nettype none

module stis_cell (
  input  logic                                clk_i,
  input  stis_pkg::cell_ctrl_t                ctrl_i,
  input  logic signed [stis_pkg::VALUE_W-1:0] key_i,
  input  logic                                occupied_i,
  input  logic                                tail_i,
  input  logic                                wrap_i,
  input  logic                                left_take_i,
  input  logic signed [stis_pkg::VALUE_W-1:0] left_entry_i,
  input  logic signed [stis_pkg::VALUE_W-1:0] right_entry_i,
  input  logic signed [stis_pkg::VALUE_W-1:0] head_entry_i,
  output logic                                take_o,
  output logic signed [stis_pkg::VALUE_W-1:0] entry_o,
  output logic                                hit_o
);

  logic signed [stis_pkg::VALUE_W-1:0] entry_q, entry_d;
  logic                                hit_q, hit_d;

  // The cell takes part in an insert when its value is not smaller than the key,
  // or when it is the first free slot. Over a sorted chain this is a suffix.
  assign take_o = (occupied_i && (entry_q >= key_i)) || tail_i;
  assign hit_d  = occupied_i && (entry_q == key_i);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift_in) begin
      if (left_take_i) begin
        entry_d = left_entry_i;
      end else if (take_o) begin
        entry_d = key_i;
      end
    end else if (ctrl_i.rotate) begin
      entry_d = wrap_i ? head_entry_i : right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    hit_q   <= hit_d;
  end

  assign entry_o = entry_q;
  assign hit_o   = hit_q;

endmodule

`default_nettype wire
